>>> design/tpg_pkg.sv
// shared types, constants and functions for the test pattern pixel block
package tpg_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int COORD_W       = 12;
    localparam int DIM_W         = $clog2(MAX_DIMENSION) + 1;
    localparam int REM_W         = $clog2(MAX_DIMENSION);
    localparam int NUM_W         = COORD_W + 8;
    localparam int DIV_STAGES    = NUM_W;
    localparam int PIPE_STAGES   = DIV_STAGES + 2;
    localparam int CFG_IDX_W     = 2;
    localparam int COLOUR_W      = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd2;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1920);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1080);

    localparam logic [COLOUR_W-1:0] COLOUR_WHITE = 32'hFFFF_FFFF;
    localparam logic [COLOUR_W-1:0] COLOUR_BLACK = 32'hFF00_0000;
    localparam logic [COLOUR_W-1:0] COLOUR_ZERO  = 32'h0000_0000;
    localparam logic [7:0]          ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]          BLUE_MID     = 8'd128;

    typedef enum logic [1:0] {
        PAT_BARS,
        PAT_GRADIENT,
        PAT_CHECKER,
        PAT_SOLID
    } t_pattern;

    // zero acts as one, oversize clamps to the maximum
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIMENSION)) begin
            res = DIM_W'(MAX_DIMENSION);
        end
        return res;
    endfunction

    function automatic logic [COLOUR_W-1:0] bar_colour(input logic [2:0] idx);
        logic [COLOUR_W-1:0] res;
        case (idx)
            3'd0:    res = 32'hFFFF_FFFF;
            3'd1:    res = 32'hFFFF_FF00;
            3'd2:    res = 32'hFF00_FFFF;
            3'd3:    res = 32'hFF00_FF00;
            3'd4:    res = 32'hFFFF_00FF;
            3'd5:    res = 32'hFFFF_0000;
            3'd6:    res = 32'hFF00_00FF;
            default: res = 32'hFF00_0000;
        endcase
        return res;
    endfunction

endpackage

>>> design/tpg_div_lane.sv
// pipelined restoring divider lane, one quotient bit per stage
module tpg_div_lane (
    input  logic                              i_clk,
    input  logic [tpg_pkg::DIV_STAGES-1:0]    i_en,
    input  logic [tpg_pkg::NUM_W-1:0]         i_num,
    input  logic [tpg_pkg::DIM_W-1:0]         i_den,
    output logic [tpg_pkg::NUM_W-1:0]         o_quot
);

    logic [tpg_pkg::NUM_W-1:0] r_num [tpg_pkg::DIV_STAGES];
    logic [tpg_pkg::REM_W-1:0] r_rem [tpg_pkg::DIV_STAGES];
    logic [tpg_pkg::NUM_W-1:0] n_num [tpg_pkg::DIV_STAGES];
    logic [tpg_pkg::REM_W-1:0] n_rem [tpg_pkg::DIV_STAGES];
    logic [tpg_pkg::NUM_W-1:0] src_num [tpg_pkg::DIV_STAGES];
    logic [tpg_pkg::REM_W-1:0] src_rem [tpg_pkg::DIV_STAGES];
    logic [tpg_pkg::DIM_W-1:0] trial [tpg_pkg::DIV_STAGES];
    logic [tpg_pkg::DIV_STAGES-1:0] fits;

    always_comb begin
        for (int j = 0; j < tpg_pkg::DIV_STAGES; j++) begin
            if (j == 0) begin
                src_num[j] = i_num;
                src_rem[j] = '0;
            end else begin
                src_num[j] = r_num[j-1];
                src_rem[j] = r_rem[j-1];
            end
            trial[j] = {src_rem[j], src_num[j][tpg_pkg::NUM_W-1]};
            fits[j]  = (trial[j] >= i_den);
            if (fits[j]) begin
                n_rem[j] = tpg_pkg::REM_W'(trial[j] - i_den);
            end else begin
                n_rem[j] = trial[j][tpg_pkg::REM_W-1:0];
            end
            n_num[j] = {src_num[j][tpg_pkg::NUM_W-2:0], fits[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < tpg_pkg::DIV_STAGES; j++) begin
            if (i_en[j]) begin
                r_num[j] <= n_num[j];
                r_rem[j] <= n_rem[j];
            end
        end
    end

    assign o_quot = r_num[tpg_pkg::DIV_STAGES-1];

endmodule

>>> design/video_test_pattern_pixel_top.sv
// test pattern pixel generator top level: config registers, pipeline control, colour stage
//
//  channel   direction  handshake                          payload
//  s_axis    in         i_s_axis_tvalid / o_s_axis_tready   column, row
//  m_axis    out        o_m_axis_tvalid / i_m_axis_tready   pixel_color
//  cfg       in         i_cfg_valid / o_cfg_ready           register index, data
//
//  one pixel per cycle sustained while the output accepts; stages: an input register,
//  twenty divider stages (one quotient bit each) and the colour register
//  each stage has its own valid bit and loads when empty or when the next one moves,
//  so bubbles close up and a stall at the output holds data without loss
//  synchronous active-low reset clears valid bits and sets the register defaults
module video_test_pattern_pixel_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [23:0]                      i_s_axis_tdata,   // column [11:0], row [23:12]
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [31:0]                      o_m_axis_tdata,   // pixel_color [31:0]
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tpg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tpg_pkg::DIM_W-1:0]        i_cfg_data
);

    localparam int NST   = tpg_pkg::PIPE_STAGES;
    localparam int CNT_W = $clog2(NST + 1);

    tpg_pkg::t_pattern             r_pattern;
    logic [tpg_pkg::DIM_W-1:0]     r_width;
    logic [tpg_pkg::DIM_W-1:0]     r_height;

    logic [NST-1:0]                r_valid;
    logic [NST-1:0]                en;
    logic [NST-2:0]                r_chk;
    logic [tpg_pkg::NUM_W-1:0]     r_num_a;
    logic [tpg_pkg::NUM_W-1:0]     r_num_b;
    logic [tpg_pkg::NUM_W-1:0]     n_num_a;
    logic [tpg_pkg::NUM_W-1:0]     n_num_b;
    logic [tpg_pkg::NUM_W-1:0]     quot_a;
    logic [tpg_pkg::NUM_W-1:0]     quot_b;
    logic [tpg_pkg::COLOUR_W-1:0]  r_colour;
    logic [tpg_pkg::COLOUR_W-1:0]  n_colour;
    logic [CNT_W-1:0]              r_cnt;

    logic [tpg_pkg::COORD_W-1:0]   col;
    logic [tpg_pkg::COORD_W-1:0]   row;
    logic                          in_acc;
    logic                          out_acc;

    assign col     = i_s_axis_tdata[tpg_pkg::COORD_W-1:0];
    assign row     = i_s_axis_tdata[2*tpg_pkg::COORD_W-1:tpg_pkg::COORD_W];
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // configuration registers hold effective dimensions
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= tpg_pkg::PAT_BARS;
            r_width   <= tpg_pkg::WIDTH_RESET;
            r_height  <= tpg_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tpg_pkg::REG_PATTERN: r_pattern <= tpg_pkg::t_pattern'(i_cfg_data[1:0]);
                tpg_pkg::REG_WIDTH:   r_width   <= tpg_pkg::eff_dim(i_cfg_data);
                tpg_pkg::REG_HEIGHT:  r_height  <= tpg_pkg::eff_dim(i_cfg_data);
                default: ;
            endcase
        end
    end

    // stage enables, from the output back
    always_comb begin
        en[NST-1] = !r_valid[NST-1] || i_m_axis_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    assign o_s_axis_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (en[k]) begin
                    r_valid[k] <= (k == 0) ? i_s_axis_tvalid : r_valid[k-1];
                end
            end
        end
    end

    // numerators: column*8 for bars, column*255 for red, row*255 for green
    always_comb begin
        if (r_pattern == tpg_pkg::PAT_BARS) begin
            n_num_a = tpg_pkg::NUM_W'({col, 3'b000});
        end else begin
            n_num_a = {col, 8'h00} - tpg_pkg::NUM_W'(col);
        end
        n_num_b = {row, 8'h00} - tpg_pkg::NUM_W'(row);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_num_a  <= n_num_a;
            r_num_b  <= n_num_b;
            r_chk[0] <= col[6] ^ row[6];
        end
        for (int k = 1; k < NST - 1; k++) begin
            if (en[k]) begin
                r_chk[k] <= r_chk[k-1];
            end
        end
    end

    tpg_div_lane u_div_x (
        .i_clk  (i_clk),
        .i_en   (en[NST-2:1]),
        .i_num  (r_num_a),
        .i_den  (r_width),
        .o_quot (quot_a)
    );

    tpg_div_lane u_div_y (
        .i_clk  (i_clk),
        .i_en   (en[NST-2:1]),
        .i_num  (r_num_b),
        .i_den  (r_height),
        .o_quot (quot_b)
    );

    always_comb begin
        case (r_pattern)
            tpg_pkg::PAT_BARS: begin
                if (quot_a[tpg_pkg::NUM_W-1:3] != '0) begin
                    n_colour = tpg_pkg::COLOUR_BLACK;
                end else begin
                    n_colour = tpg_pkg::bar_colour(quot_a[2:0]);
                end
            end
            tpg_pkg::PAT_GRADIENT: begin
                n_colour = {tpg_pkg::ALPHA_OPAQUE, quot_a[7:0], quot_b[7:0],
                            tpg_pkg::BLUE_MID};
            end
            tpg_pkg::PAT_CHECKER: begin
                n_colour = r_chk[NST-2] ? tpg_pkg::COLOUR_BLACK : tpg_pkg::COLOUR_WHITE;
            end
            default: begin
                n_colour = tpg_pkg::COLOUR_ZERO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[NST-1]) begin
            r_colour <= n_colour;
        end
    end

    assign o_m_axis_tvalid = r_valid[NST-1];
    assign o_m_axis_tdata  = r_colour;

    // transactions in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CNT_W'(in_acc) - CNT_W'(out_acc);
        end
    end

    a_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == CNT_W'($countones(r_valid)))
        else $error("in-flight count disagrees with stage valid bits");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_valid[0])
        else $error("accepted transaction missing from input stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && !r_valid[0])
        else $error("pipeline not empty after reset");

endmodule
